>>> rtl/hks_pkg.sv
// shared types and constants for the hashed key set
`timescale 1ns / 1ps
package hks_pkg;

    localparam int KEY_W      = 64;
    localparam int CHUNK_W    = 8;
    localparam int NUM_CHUNKS = KEY_W / CHUNK_W;
    localparam int HASH_STEPS = 4;
    localparam int HCNT_W     = $clog2(HASH_STEPS);

    typedef enum logic [1:0] {
        FUNC_FIND   = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [KEY_W-1:0]  key;
    } t_in_item;

    typedef struct packed {
        logic success;
        logic bucket_full;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch an accepted item
        logic hash_step;  // one stage of the bucket reduction
        logic rd;         // read the bucket row
        logic upd;        // compare, write back, load result
        logic clr_step;   // clear one bucket row
        logic clr_res;    // load the clear result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hash_done;
        logic clr_last;
    } t_sts;

endpackage

>>> rtl/hks_dp.sv
// datapath of the hashed key set: bucket reduction, bucket memories, compare
`timescale 1ns / 1ps
module hks_dp
    import hks_pkg::*;
#(
    parameter int NUM_BUCKETS = 211,
    parameter int BUCKET_WAYS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_out_data
);

    localparam int RW     = $clog2(NUM_BUCKETS);
    localparam int FOLD_W = RW + CHUNK_W + $clog2(NUM_CHUNKS);
    localparam int PROD_W = 2 * FOLD_W;

    // weight of each key byte: 256 to the byte position, modulo the bucket count
    function automatic logic [NUM_CHUNKS-1:0][RW-1:0] fold_weights();
        logic [NUM_CHUNKS-1:0][RW-1:0] wt;
        int                            p;
        p = 1;
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            wt[c] = RW'(p);
            p     = (p * 256) % NUM_BUCKETS;
        end
        return wt;
    endfunction

    localparam logic [NUM_CHUNKS-1:0][RW-1:0] FOLD_WT = fold_weights();
    // floor of 2**FOLD_W over the bucket count, quotient low by at most one
    localparam logic [FOLD_W-1:0] RECIP = FOLD_W'((64'd1 << FOLD_W) / 64'(NUM_BUCKETS));

    // bucket memories, one row per bucket
    logic [BUCKET_WAYS-1:0][KEY_W-1:0] r_key_mem [NUM_BUCKETS];
    logic [BUCKET_WAYS-1:0]            r_vld_mem [NUM_BUCKETS];

    logic [BUCKET_WAYS-1:0][KEY_W-1:0] r_key_row;
    logic [BUCKET_WAYS-1:0]            r_vld_row;

    t_func            r_func;
    logic [KEY_W-1:0] r_key;
    logic [FOLD_W-1:0] r_fold;
    logic [FOLD_W-1:0] r_quo;
    logic [FOLD_W-1:0] r_diff;
    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    n_rem;
    logic [HCNT_W-1:0] r_hcnt;
    logic [RW-1:0]    r_clr_cnt;
    t_out_item        r_out;

    logic [FOLD_W-1:0]      fold;
    logic [PROD_W-1:0]      prod;
    logic [BUCKET_WAYS-1:0] hit;
    logic [BUCKET_WAYS-1:0] free_oh;
    logic [BUCKET_WAYS-1:0] n_vld_row;
    logic [BUCKET_WAYS-1:0] key_we;
    logic                   found;
    logic                   has_free;
    logic                   succ;
    logic                   full;
    logic                   vld_we;
    logic [RW-1:0]          vld_waddr;
    logic [BUCKET_WAYS-1:0] vld_wdata;

    // key folded to a short value with the same remainder
    always_comb begin
        fold = '0;
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            fold = fold + FOLD_W'(r_key[c*CHUNK_W +: CHUNK_W]) * FOLD_W'(FOLD_WT[c]);
        end
    end

    assign prod = PROD_W'(r_fold) * PROD_W'(RECIP);

    // difference is below twice the bucket count, one subtract finishes it
    assign n_rem = (r_diff >= FOLD_W'(NUM_BUCKETS)) ?
                   RW'(r_diff - FOLD_W'(NUM_BUCKETS)) : RW'(r_diff);

    always_comb begin
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            hit[w] = r_vld_row[w] && (r_key_row[w] == r_key);
        end
    end

    assign found    = |hit;
    assign has_free = |(~r_vld_row);
    // lowest clear bit of the valid row
    assign free_oh  = ~r_vld_row & (r_vld_row + BUCKET_WAYS'(1));

    always_comb begin
        succ      = 1'b0;
        full      = 1'b0;
        n_vld_row = r_vld_row;
        key_we    = '0;
        case (r_func)
            FUNC_FIND: begin
                succ = found;
            end
            FUNC_INSERT: begin
                succ = !found && has_free;
                full = !found && !has_free;
                if (!found && has_free) begin
                    n_vld_row = r_vld_row | free_oh;
                    key_we    = free_oh;
                end
            end
            FUNC_REMOVE: begin
                succ      = found;
                n_vld_row = r_vld_row & ~hit;
            end
            default: begin
                succ = 1'b1;
            end
        endcase
    end

    assign vld_we    = i_cmd.upd || i_cmd.clr_step;
    assign vld_waddr = i_cmd.clr_step ? r_clr_cnt : r_rem;
    assign vld_wdata = i_cmd.clr_step ? '0 : n_vld_row;

    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            r_vld_mem[vld_waddr] <= vld_wdata;
        end
        if (i_cmd.rd) begin
            r_vld_row <= r_vld_mem[r_rem];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            for (int w = 0; w < BUCKET_WAYS; w++) begin
                if (key_we[w]) begin
                    r_key_mem[r_rem][w] <= r_key;
                end
            end
        end
        if (i_cmd.rd) begin
            r_key_row <= r_key_mem[r_rem];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in_data.func;
            r_key  <= i_in_data.key;
        end
        // reduction stages advance together, the last one is valid after all steps
        if (i_cmd.hash_step) begin
            r_fold <= fold;
            r_quo  <= prod[PROD_W-1 -: FOLD_W];
            r_diff <= r_fold - r_quo * FOLD_W'(NUM_BUCKETS);
        end
        if (i_cmd.upd) begin
            r_out.success     <= succ;
            r_out.bucket_full <= full;
        end else if (i_cmd.clr_res) begin
            r_out.success     <= 1'b1;
            r_out.bucket_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_hcnt    <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_rem  <= '0;
                r_hcnt <= '0;
            end else if (i_cmd.hash_step) begin
                r_rem  <= n_rem;
                r_hcnt <= r_hcnt + HCNT_W'(1);
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= o_sts.clr_last ? '0 : r_clr_cnt + RW'(1);
            end
        end
    end

    assign o_sts.hash_done = (r_hcnt == HCNT_W'(HASH_STEPS - 1));
    assign o_sts.clr_last  = (r_clr_cnt == RW'(NUM_BUCKETS - 1));
    assign o_out_data      = r_out;

    a_bucket_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_rem < RW'(NUM_BUCKETS - 1)) || (r_rem == RW'(NUM_BUCKETS - 1)))
        else $error("bucket index beyond bucket count");

    a_no_duplicate_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |-> $onehot0(hit))
        else $error("key held in more than one way of a bucket");

endmodule

>>> rtl/hks_ctrl.sv
// controller of the hashed key set: sequencing of lookups, updates and clears
`timescale 1ns / 1ps
module hks_ctrl
    import hks_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_func i_in_func,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CMP,
        S_CLEAR,
        S_CLR_RES
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   slot_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign slot_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_func == FUNC_CLEAR) ? S_CLEAR : S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (slot_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_CLR_RES;
                end
            end
            S_CLR_RES: begin
                if (slot_free) begin
                    o_cmd.clr_res = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.upd || o_cmd.clr_res) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.upd || o_cmd.clr_res) |-> slot_free)
        else $error("result loaded over an item not yet taken");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.upd || o_cmd.clr_res) |=> r_out_valid)
        else $error("loaded result not presented");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("second item accepted while one is in work");

endmodule

>>> rtl/hashed_key_set.sv
// top level of the hashed key set: controller plus datapath
// find/insert/remove: the accepted item passes these steps; compare waits for a free output
//   (4 reduction steps: byte fold, reciprocal quotient, difference, final subtract; read; compare)
// clear: one bucket row cleared per cycle, then the result loads once the output is free
// one item in work: input stalls until the result loads and the controller is back in idle
// reset: synchronous, active low; all bucket rows are then cleared with input stalled
`timescale 1ns / 1ps
module hashed_key_set
    import hks_pkg::*;
#(
    parameter int NUM_BUCKETS = 211,
    parameter int BUCKET_WAYS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_cmd cmd;
    t_sts sts;

    hks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_func   (i_in_data.func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hks_dp #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BUCKET_WAYS (BUCKET_WAYS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule
